// ===== hdl/assert_macros.svh =====
// Assertion macros for the RTL files; the list engine includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_CLK(label, clk, rst_n, prop, msg)
`define ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

// ===== hdl/dll_pkg.sv =====
`default_nettype none
package dll_pkg;

  localparam int unsigned CmdBits    = 3;
  localparam int unsigned InValBits  = 32;
  localparam int unsigned PosBits    = 9;
  localparam int unsigned StatusBits = 2;
  localparam int unsigned CountBits  = 9;

  typedef enum logic [CmdBits-1:0] {
    CMD_APPEND     = 3'd0,
    CMD_PUSH_FRONT = 3'd1,
    CMD_INSERT_AT  = 3'd2,
    CMD_DEL_FRONT  = 3'd3,
    CMD_DEL_END    = 3'd4,
    CMD_DEL_AT     = 3'd5,
    CMD_SEARCH     = 3'd6,
    CMD_UNUSED     = 3'd7
  } cmd_e;

  typedef enum logic [StatusBits-1:0] {
    ST_OK      = 2'd0,
    ST_BAD_POS = 2'd1,
    ST_EMPTY   = 2'd2,
    ST_FULL    = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_WALK,
    S_WALK_WAIT,
    S_SEARCH_WAIT,
    S_INS_POP,
    S_INS_LINK,
    S_DEL_RD,
    S_DEL_WAIT,
    S_DEL_LINK,
    S_DONE
  } state_e;

  typedef struct packed {
    cmd_e                command;
    logic [InValBits-1:0] value;
    logic [PosBits-1:0]  position;
  } req_t;

  typedef struct packed {
    status_e              status;
    logic                 found;
    logic [CountBits-1:0] count;
  } rsp_t;

endpackage
`default_nettype wire

// ===== hdl/dll_if.sv =====
`default_nettype none
interface dll_req_if;
  import dll_pkg::*;
  logic valid;
  logic ready;
  req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface dll_rsp_if;
  import dll_pkg::*;
  logic valid;
  logic ready;
  rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== hdl/doubly_linked_list_engine.sv =====
// A refused or unused command goes to its result without touching the memories. Append,
// push front, an insert at the tail position and the head or tail deletes reach their
// nodes without a walk. Insert at, delete at and search walk the next links from the head,
// issuing a memory read and then consuming it for each node that they pass.
// One command is worked at a time; the next is taken only once the result has been accepted.
// Reset is asynchronous and active low; it empties the list at once with no clearing pass.
`default_nettype none
`include "assert_macros.svh"
module doubly_linked_list_engine #(
  parameter int unsigned CAPACITY   = 256,
  parameter int unsigned VALUE_BITS = 32
) (
  input wire logic clk_i,
  input wire logic rst_ni,
  dll_req_if.sink   req_i,
  dll_rsp_if.source rsp_o
);
  import dll_pkg::*;

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned LW = AW + 1;
  localparam logic [LW-1:0] NIL = LW'(CAPACITY);

  state_e state_q, state_d;
  req_t   req_q, req_d;
  rsp_t   rsp_q, rsp_d;
  logic   rsp_valid_q, rsp_valid_d;
  logic [LW-1:0] head_q, head_d, tail_q, tail_d, count_q, count_d;
  logic [LW-1:0] fresh_q, fresh_d, rtop_q, rtop_d;
  logic [LW-1:0] cur_q, cur_d, idx_q, idx_d, slot_q, slot_d;
  logic [LW-1:0] bef_q, bef_d, aft_q, aft_d;
  logic [1:0]    step_q, step_d;

  logic            nx_we, pv_we, vl_we, rc_we;
  logic [AW-1:0]   nx_wa, pv_wa, vl_wa, rc_wa, nx_ra, pv_ra, vl_ra, rc_ra;
  logic [LW-1:0]   nx_wd, pv_wd, nx_rd, pv_rd;
  logic [VALUE_BITS-1:0] vl_wd, vl_rd;
  logic [AW-1:0]   rc_wd, rc_rd;

  dll_ram #(.Depth(CAPACITY), .Width(LW)) u_next (
    .clk_i, .we_i(nx_we), .waddr_i(nx_wa), .wdata_i(nx_wd), .raddr_i(nx_ra), .rdata_o(nx_rd));
  dll_ram #(.Depth(CAPACITY), .Width(LW)) u_prev (
    .clk_i, .we_i(pv_we), .waddr_i(pv_wa), .wdata_i(pv_wd), .raddr_i(pv_ra), .rdata_o(pv_rd));
  dll_ram #(.Depth(CAPACITY), .Width(VALUE_BITS)) u_val (
    .clk_i, .we_i(vl_we), .waddr_i(vl_wa), .wdata_i(vl_wd), .raddr_i(vl_ra), .rdata_o(vl_rd));
  dll_ram #(.Depth(CAPACITY), .Width(AW)) u_rec (
    .clk_i, .we_i(rc_we), .waddr_i(rc_wa), .wdata_i(rc_wd), .raddr_i(rc_ra), .rdata_o(rc_rd));

  logic [VALUE_BITS-1:0] key;
  logic                  full, pos_gt, pos_eq;
  assign key  = req_q.value[VALUE_BITS-1:0];
  assign full = (count_q >= NIL) || ((rtop_q == '0) && (fresh_q >= NIL));
  assign pos_gt = ({{(LW > PosBits ? LW - PosBits : 1){1'b0}}, req_q.position} >
                   {{(PosBits > LW ? PosBits - LW : 1){1'b0}}, count_q});
  assign pos_eq = ({{(LW > PosBits ? LW - PosBits : 1){1'b0}}, req_q.position} ==
                   {{(PosBits > LW ? PosBits - LW : 1){1'b0}}, count_q});

  assign req_i.ready = (state_q == S_IDLE) && !rsp_valid_q;
  assign rsp_o.valid = rsp_valid_q;
  assign rsp_o.data  = rsp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      rsp_valid_q <= 1'b0;
      head_q <= NIL;
      tail_q <= NIL;
      count_q <= '0;
      fresh_q <= '0;
      rtop_q <= '0;
    end else begin
      state_q <= state_d;
      rsp_valid_q <= rsp_valid_d;
      head_q <= head_d;
      tail_q <= tail_d;
      count_q <= count_d;
      fresh_q <= fresh_d;
      rtop_q <= rtop_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q <= req_d;
    rsp_q <= rsp_d;
    cur_q <= cur_d;
    idx_q <= idx_d;
    slot_q <= slot_d;
    bef_q <= bef_d;
    aft_q <= aft_d;
    step_q <= step_d;
  end

  always_comb begin
    state_d = state_q;
    req_d = req_q;
    rsp_d = rsp_q;
    rsp_valid_d = rsp_valid_q;
    head_d = head_q;
    tail_d = tail_q;
    count_d = count_q;
    fresh_d = fresh_q;
    rtop_d = rtop_q;
    cur_d = cur_q;
    idx_d = idx_q;
    slot_d = slot_q;
    bef_d = bef_q;
    aft_d = aft_q;
    step_d = step_q;
    nx_we = 1'b0;
    pv_we = 1'b0;
    vl_we = 1'b0;
    rc_we = 1'b0;
    nx_wa = '0;
    pv_wa = '0;
    vl_wa = '0;
    rc_wa = rtop_q[AW-1:0];
    nx_wd = '0;
    pv_wd = '0;
    vl_wd = key;
    rc_wd = slot_q[AW-1:0];
    nx_ra = cur_q[AW-1:0];
    pv_ra = cur_q[AW-1:0];
    vl_ra = cur_q[AW-1:0];
    rc_ra = AW'(rtop_q - 1'b1);

    if (rsp_valid_q && rsp_o.ready) begin
      rsp_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (req_i.valid && req_i.ready) begin
          req_d = req_i.data;
          state_d = S_DONE;
          rsp_d.status = ST_OK;
          rsp_d.found = 1'b0;
          unique case (req_i.data.command)
            CMD_APPEND, CMD_PUSH_FRONT, CMD_INSERT_AT: begin
              state_d = S_WALK;
              step_d = 2'd0;
            end
            CMD_DEL_FRONT, CMD_DEL_END: begin
              state_d = S_WALK;
              step_d = 2'd0;
            end
            CMD_DEL_AT, CMD_SEARCH: begin
              state_d = S_WALK;
              step_d = 2'd0;
            end
            default: rsp_d.status = ST_BAD_POS;
          endcase
        end
      end

      S_WALK: begin
        // Decode the accepted transaction against the current list state.
        unique case (req_q.command)
          CMD_APPEND: begin
            bef_d = tail_q;
            aft_d = NIL;
            state_d = full ? S_DONE : S_INS_POP;
            rsp_d.status = full ? ST_FULL : ST_OK;
          end
          CMD_PUSH_FRONT: begin
            bef_d = NIL;
            aft_d = head_q;
            state_d = full ? S_DONE : S_INS_POP;
            rsp_d.status = full ? ST_FULL : ST_OK;
          end
          CMD_INSERT_AT: begin
            if (pos_gt) begin
              rsp_d.status = ST_BAD_POS;
              state_d = S_DONE;
            end else if (full) begin
              rsp_d.status = ST_FULL;
              state_d = S_DONE;
            end else if (pos_eq) begin
              bef_d = tail_q;
              aft_d = NIL;
              state_d = S_INS_POP;
            end else begin
              cur_d = head_q;
              idx_d = '0;
              state_d = S_WALK_WAIT;
              step_d = 2'd0;
            end
          end
          CMD_DEL_FRONT, CMD_DEL_END: begin
            if (count_q == '0) begin
              rsp_d.status = ST_EMPTY;
              state_d = S_DONE;
            end else begin
              cur_d = (req_q.command == CMD_DEL_FRONT) ? head_q : tail_q;
              state_d = S_DEL_RD;
            end
          end
          CMD_DEL_AT: begin
            if (pos_gt || pos_eq) begin
              rsp_d.status = ST_BAD_POS;
              state_d = S_DONE;
            end else begin
              cur_d = head_q;
              idx_d = '0;
              state_d = S_WALK_WAIT;
              step_d = 2'd0;
            end
          end
          CMD_SEARCH: begin
            cur_d = head_q;
            state_d = (head_q == NIL) ? S_DONE : S_SEARCH_WAIT;
            step_d = 2'd0;
          end
          default: state_d = S_DONE;
        endcase
      end

      S_WALK_WAIT: begin
        // Step 0 issues the read of cur, step 1 consumes it.
        if (step_q == 2'd0) begin
          if ({{(PosBits > LW ? PosBits - LW : 1){1'b0}}, idx_q} ==
              {{(LW > PosBits ? LW - PosBits : 1){1'b0}}, req_q.position}) begin
            state_d = S_DEL_RD;
          end else begin
            step_d = 2'd1;
          end
        end else begin
          cur_d = nx_rd;
          idx_d = idx_q + 1'b1;
          step_d = 2'd0;
        end
      end

      S_SEARCH_WAIT: begin
        if (step_q == 2'd0) begin
          step_d = 2'd1;
        end else if (vl_rd == key) begin
          rsp_d.found = 1'b1;
          state_d = S_DONE;
        end else begin
          cur_d = nx_rd;
          step_d = 2'd0;
          if (nx_rd == NIL) begin
            state_d = S_DONE;
          end
        end
      end

      S_DEL_RD: begin
        state_d = S_DEL_WAIT;
      end

      S_DEL_WAIT: begin
        if (req_q.command == CMD_INSERT_AT) begin
          bef_d = pv_rd;
          aft_d = cur_q;
          state_d = S_INS_POP;
        end else begin
          bef_d = pv_rd;
          aft_d = nx_rd;
          slot_d = cur_q;
          state_d = S_DEL_LINK;
        end
      end

      S_DEL_LINK: begin
        if (bef_q == NIL) begin
          head_d = aft_q;
        end else begin
          nx_we = 1'b1;
          nx_wa = bef_q[AW-1:0];
          nx_wd = aft_q;
        end
        if (aft_q == NIL) begin
          tail_d = bef_q;
        end else begin
          pv_we = 1'b1;
          pv_wa = aft_q[AW-1:0];
          pv_wd = bef_q;
        end
        if (rtop_q < NIL) begin
          rc_we = 1'b1;
          rtop_d = rtop_q + 1'b1;
        end
        count_d = count_q - 1'b1;
        state_d = S_DONE;
      end

      S_INS_POP: begin
        // The recycled stack read is issued here and lands next cycle.
        if (rtop_q != '0) begin
          rtop_d = rtop_q - 1'b1;
          step_d = 2'd1;
        end else begin
          slot_d = fresh_q;
          fresh_d = fresh_q + 1'b1;
          step_d = 2'd0;
        end
        state_d = S_INS_LINK;
      end

      S_INS_LINK: begin
        slot_d = (step_q == 2'd1) ? {1'b0, rc_rd} : slot_q;
        nx_we = 1'b1;
        nx_wa = slot_d[AW-1:0];
        nx_wd = aft_q;
        pv_we = 1'b1;
        pv_wa = slot_d[AW-1:0];
        pv_wd = bef_q;
        vl_we = 1'b1;
        vl_wa = slot_d[AW-1:0];
        step_d = 2'd2;
        if (step_q == 2'd2) begin
          nx_we = 1'b0;
          pv_we = 1'b0;
          vl_we = 1'b0;
          if (bef_q == NIL) begin
            head_d = slot_q;
          end else begin
            nx_we = 1'b1;
            nx_wa = bef_q[AW-1:0];
            nx_wd = slot_q;
          end
          if (aft_q == NIL) begin
            tail_d = slot_q;
          end else begin
            pv_we = 1'b1;
            pv_wa = aft_q[AW-1:0];
            pv_wd = slot_q;
          end
          count_d = count_q + 1'b1;
          state_d = S_DONE;
        end
      end

      S_DONE: begin
        rsp_d.count = CountBits'(count_q);
        rsp_valid_d = 1'b1;
        state_d = S_IDLE;
      end

      default: state_d = S_IDLE;
    endcase
  end

  `ASSERT_CLK(a_cnt_range, clk_i, rst_ni, count_q <= NIL, "count exceeds capacity")
  `ASSERT_CLK(a_empty_nil, clk_i, rst_ni, (count_q == '0) |-> (head_q == NIL && tail_q == NIL), "empty list has a head or tail")
  `ASSERT_CLK(a_rsp_hold, clk_i, rst_ni, (rsp_valid_q && !rsp_o.ready) |=> $stable(rsp_q), "result changed while stalled")
  `ASSERT_CLK(a_one_busy, clk_i, rst_ni, rsp_valid_q |-> (state_q == S_IDLE), "result pending while busy")

endmodule
`default_nettype wire

// ===== hdl/dll_ram.sv =====
`default_nettype none
module dll_ram #(
  parameter int unsigned Depth = 256,
  parameter int unsigned Width = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end
endmodule
`default_nettype wire
